@@ sv/hcr_pkg.sv @@
// shared types, character constants and decode functions for the character reference decoder
`default_nettype none
package hcr_pkg;

  localparam int MaxOut = 6;

  // match stage codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AMP  = 3'd1;
  localparam logic [2:0] ST_HASH = 3'd2;
  localparam logic [2:0] ST_X    = 3'd3;
  localparam logic [2:0] ST_C1   = 3'd4;
  localparam logic [2:0] ST_C2   = 3'd5;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] LEAD_C2  = 8'hC2;
  localparam logic [7:0] LEAD_C3  = 8'hC3;

  localparam logic [3:0] HIGH_TAB [4] = '{4'd8, 4'd9, 4'd10, 4'd11};

  typedef struct packed {
    logic [2:0] stage;
    logic [7:0] first;
    logic [7:0] second;
  } match_t;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [2:0]             count;
  } obytes_t;

  typedef struct packed {
    match_t  m;
    obytes_t o;
  } work_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UF) ||
           (b >= CH_LA && b <= CH_LF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= CH_0 && b <= CH_9) v = b - CH_0;
    else if (b >= CH_LA && b <= CH_LF) v = b - CH_LA + 8'd10;
    else if (b >= CH_UA && b <= CH_UF) v = b - CH_UA + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) ? b - 8'd32 : b;
  endfunction

  function automatic obytes_t put_byte(input obytes_t o, input logic [7:0] b);
    obytes_t r;
    r = o;
    if (r.count < 3'(MaxOut)) begin
      r.data[r.count] = b;
      r.count = r.count + 3'd1;
    end
    return r;
  endfunction

  function automatic obytes_t put_prefix(input obytes_t o, input logic [2:0] s);
    obytes_t r;
    r = o;
    if (s >= ST_AMP) r = put_byte(r, CH_AMP);
    if (s >= ST_HASH) r = put_byte(r, CH_HASH);
    if (s >= ST_X) r = put_byte(r, CH_X);
    return r;
  endfunction

  // matcher for the idle and prefix stages
  function automatic work_t scan(input work_t w, input logic [7:0] b);
    work_t      r;
    logic [2:0] s;
    r = w;
    s = w.m.stage;
    if (s == ST_AMP && b == CH_HASH) begin
      r.m.stage = ST_HASH;
    end else if (s == ST_HASH && b == CH_X) begin
      r.m.stage = ST_X;
    end else if (s == ST_X && b != 8'd0) begin
      r.m.first = b;
      r.m.stage = ST_C1;
    end else begin
      if (s >= ST_AMP && s <= ST_X) r.o = put_prefix(r.o, s);
      if (b == CH_AMP) begin
        r.m.stage = ST_AMP;
      end else begin
        r.m.stage = ST_IDLE;
        r.o = put_byte(r.o, b);
      end
    end
    return r;
  endfunction

  function automatic obytes_t decode(input obytes_t o, input logic [7:0] first,
                                     input logic [7:0] second);
    obytes_t    r;
    logic [7:0] c1;
    logic [3:0] lo;
    logic [7:0] off;
    r = o;
    c1 = upper(first);
    lo = hex_val(second);
    off = c1 - CH_UC;
    if (c1 >= CH_0 && c1 <= CH_9) begin
      r = put_byte(r, {hex_val(c1), lo});
    end else if (c1 >= CH_UA && c1 <= CH_UB) begin
      r = put_byte(r, LEAD_C2);
      r = put_byte(r, {hex_val(c1), lo});
    end else if (c1 >= CH_UC && c1 <= CH_UF) begin
      r = put_byte(r, LEAD_C3);
      r = put_byte(r, {HIGH_TAB[off[1:0]], lo});
    end else begin
      r = put_byte(r, CH_QUEST);
    end
    return r;
  endfunction

  // full step for one input byte: result words and next match state
  function automatic work_t step(input match_t st, input logic [7:0] b, input logic eos);
    work_t      w;
    logic [7:0] f;
    logic [7:0] s2;
    logic [2:0] s;
    w.m = st;
    w.o = '0;
    if (w.m.stage > ST_C2) w.m.stage = ST_IDLE;
    f = w.m.first;
    s2 = w.m.second;
    unique case (w.m.stage)
      ST_C1: begin
        if (is_hex(b)) begin
          w.m.second = b;
          w.m.stage = ST_C2;
        end else begin
          w.o = put_prefix(w.o, ST_X);
          w.m.stage = ST_IDLE;
          w = scan(w, f);
          w = scan(w, b);
        end
      end
      ST_C2: begin
        if (b == CH_SEMI) begin
          w.o = decode(w.o, f, s2);
          w.m.stage = ST_IDLE;
        end else begin
          w.o = put_prefix(w.o, ST_X);
          w.m.stage = ST_IDLE;
          w = scan(w, f);
          w = scan(w, s2);
          w = scan(w, b);
        end
      end
      default: begin
        w = scan(w, b);
      end
    endcase
    if (eos) begin
      s = w.m.stage;
      w.o = put_prefix(w.o, s);
      if (s >= ST_C1) w.o = put_byte(w.o, w.m.first);
      if (s >= ST_C2) w.o = put_byte(w.o, w.m.second);
      w.m = '0;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

@@ sv/hex_char_ref_to_utf8.sv @@
// top level: input register, decoder and output word buffer
// an accepted input word goes through the input register and then the output buffer to its first output word
// throughput: one output word per cycle while m_tready is high; one input word per cycle while each
//   gives at most one output word, otherwise the output buffer drain sets the pace
// an input word is taken while the buffer still holds results for the previous one
// rst is synchronous: clears match state, input register and output buffer
`default_nettype none
module hex_char_ref_to_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // end_of_stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast    // out_last
);
  import hcr_pkg::*;

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_eos;
  logic [MaxOut-1:0][7:0] obuf;
  logic [2:0]             cnt;
  logic                   buf_last;
  logic                   load;
  logic                   take;
  obytes_t                res;

  hcr_match u_match (
    .clk     (clk),
    .rst     (rst),
    .step_en (load),
    .in_byte (in_byte),
    .eos     (in_eos),
    .result  (res)
  );

  // refill the buffer when it is empty or its last word leaves now
  assign load     = in_valid && (cnt == 3'd0 || (cnt == 3'd1 && m_tready));
  assign take     = m_tvalid && m_tready;
  assign s_tready = !in_valid || load;
  assign m_tvalid = cnt != 3'd0;
  assign m_tdata  = obuf[0];
  assign m_tlast  = buf_last && cnt == 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cnt      <= 3'd0;
      buf_last <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) in_valid <= 1'b1;
      else if (load) in_valid <= 1'b0;
      if (load) begin
        cnt      <= res.count;
        buf_last <= in_eos;
      end else if (take) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
    end
    if (load) obuf <= res.data;
    else if (take) obuf <= {8'h00, obuf[MaxOut-1:1]};
  end

endmodule
`default_nettype wire

@@ sv/hcr_match.sv @@
// match state and per-byte decode of the character reference pattern
`default_nettype none
module hcr_match (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  logic [7:0]      in_byte,
  input  logic            eos,
  output hcr_pkg::obytes_t result
);
  import hcr_pkg::*;

  match_t st;
  work_t  w;

  always_comb begin
    w = step(st, in_byte, eos);
    result = w.o;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= w.m;
    end
  end

endmodule
`default_nettype wire

@@ sv/hcr_check.sv @@
// port-level checks for the character reference decoder, bound to the top level
`default_nettype none
module hcr_check (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // nothing is shown straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // with the output empty the input side never blocks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output empty");

  // a new burst of output words traces back to an accepted input word, through the input register and the output buffer
  a_burst_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) && !$past(rst) && !$past(rst, 2)
      |-> $past(s_tvalid && s_tready, 2))
    else $error("output appeared without an input word");

endmodule

bind hex_char_ref_to_utf8 hcr_check u_hcr_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

@@ sim/hex_char_ref_to_utf8_tb.sv @@
// self-checking testbench for the character reference decoder: random stream traffic on both sides
`default_nettype none
module hex_char_ref_to_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcr_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int RandomItems = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       drain;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // in_byte
  logic       s_tlast = 1'b0;   // end_of_stream
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // out_byte
  logic       m_tlast;          // out_last

  // decoder state as seen by the predictor
  logic [2:0] dec_stage = ST_IDLE;
  logic [7:0] dec_c1 = 8'd0;
  logic [7:0] dec_c2 = 8'd0;
  logic [7:0] step_bytes[$];

  byte_item_t  pending_bytes[$];
  word_t       expected_words[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  byte_item_t  tx_cur;
  bit          tx_have = 1'b0;
  bit          tx_fast = 1'b0;
  int unsigned tx_hold = 0;
  bit          rx_fast = 1'b0;
  int unsigned rx_hold = 0;

  hex_char_ref_to_utf8 u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic bit hexdigit_ok(input logic [7:0] b);
    logic [7:0] folded;
    folded = b | 8'h20;
    return (b >= CH_0 && b <= CH_9) || (folded >= CH_LA && folded <= CH_LF);
  endfunction

  // valid only for hex digits: letters in either case carry value minus 9 in the low nibble
  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    if (b >= CH_0 && b <= CH_9) return b[3:0];
    return b[3:0] + 4'd9;
  endfunction

  function automatic void emit(input logic [7:0] b);
    step_bytes.push_back(b);
  endfunction

  function automatic void emit_prefix(input logic [2:0] s);
    if (s >= ST_AMP) emit(CH_AMP);
    if (s >= ST_HASH) emit(CH_HASH);
    if (s >= ST_X) emit(CH_X);
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    if (dec_stage == ST_AMP && b == CH_HASH) begin
      dec_stage = ST_HASH;
    end else if (dec_stage == ST_HASH && b == CH_X) begin
      dec_stage = ST_X;
    end else if (dec_stage == ST_X && b != 8'd0) begin
      dec_c1 = b;
      dec_stage = ST_C1;
    end else begin
      emit_prefix(dec_stage);
      if (b == CH_AMP) begin
        dec_stage = ST_AMP;
      end else begin
        dec_stage = ST_IDLE;
        emit(b);
      end
    end
  endfunction

  function automatic void decode_entity();
    logic [7:0] c;
    logic [3:0] lo;
    c = dec_c1;
    if (c >= CH_LA && c <= CH_LZ) c = c - 8'd32;
    lo = nibble_of(dec_c2);
    if (c >= CH_0 && c <= CH_9) begin
      emit({c[3:0], lo});
    end else if (c >= CH_UA && c <= CH_UB) begin
      emit(LEAD_C2);
      emit({nibble_of(c), lo});
    end else if (c >= CH_UC && c <= CH_UF) begin
      // C..F map to high nibbles 8..11
      emit(LEAD_C3);
      emit({nibble_of(c) - 4'd4, lo});
    end else begin
      emit(CH_QUEST);
    end
  endfunction

  // works out the output words for one accepted input word
  function automatic void predict_words(input logic [7:0] b, input logic eos);
    logic [7:0] c1;
    logic [7:0] c2;
    logic [2:0] s;
    step_bytes.delete();
    if (dec_stage > ST_C2) dec_stage = ST_IDLE;
    c1 = dec_c1;
    c2 = dec_c2;
    case (dec_stage)
      ST_C1: begin
        if (hexdigit_ok(b)) begin
          dec_c2 = b;
          dec_stage = ST_C2;
        end else begin
          emit_prefix(ST_X);
          dec_stage = ST_IDLE;
          scan_byte(c1);
          scan_byte(b);
        end
      end
      ST_C2: begin
        if (b == CH_SEMI) begin
          decode_entity();
          dec_stage = ST_IDLE;
        end else begin
          emit_prefix(ST_X);
          dec_stage = ST_IDLE;
          scan_byte(c1);
          scan_byte(c2);
          scan_byte(b);
        end
      end
      default: begin
        scan_byte(b);
      end
    endcase
    if (eos) begin
      s = dec_stage;
      emit_prefix(s);
      if (s >= ST_C1) emit(dec_c1);
      if (s >= ST_C2) emit(dec_c2);
      dec_stage = ST_IDLE;
      dec_c1 = 8'd0;
      dec_c2 = 8'd0;
    end
    foreach (step_bytes[i])
      expected_words.push_back('{data: step_bytes[i],
                                 last: eos && (i == step_bytes.size() - 1)});
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic eos, input logic drain);
    pending_bytes.push_back('{data: b, eos: eos, drain: drain});
  endfunction

  function automatic void push_text(input string t, input logic eos);
    for (int i = 0; i < t.len(); i++) push_byte(t[i], eos && (i == t.len() - 1), 1'b0);
  endfunction

  function automatic logic [7:0] rand_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // one '&#x' c1 c2 ';' sequence with random content, sometimes broken or cut by end of stream
  function automatic void push_ref_seq();
    logic [7:0] seq[6];
    int         len;
    int         mode;
    int         eos_pos;
    seq[0] = CH_AMP;
    seq[1] = CH_HASH;
    seq[2] = CH_X;
    seq[3] = ($urandom_range(0, 9) < 7) ? rand_hex() : 8'($urandom_range(1, 255));
    seq[4] = ($urandom_range(0, 9) < 9) ? rand_hex() : 8'($urandom_range(0, 255));
    seq[5] = CH_SEMI;
    len = 6;
    mode = $urandom_range(0, 9);
    if (mode == 7) seq[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
    if (mode == 8) len = $urandom_range(1, 5);
    if (mode == 9) seq[$urandom_range(3, 4)] = 8'd0;
    eos_pos = -1;
    if ($urandom_range(0, 5) == 0) eos_pos = len - 1;
    else if ($urandom_range(0, 11) == 0) eos_pos = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) push_byte(seq[i], i == eos_pos, 1'b0);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_words(tx_cur.data, tx_cur.eos);
        tx_have = 1'b0;
      end
      if (!tx_have && pending_bytes.size() != 0) begin
        tx_cur = pending_bytes.pop_front();
        tx_have = 1'b1;
        if ($urandom_range(0, 15) == 0) tx_fast = !tx_fast;
        tx_hold = tx_fast ? 0 : $urandom_range(0, 7);
      end
      // a drain word waits until every expected word has come out
      if (tx_have && tx_hold == 0 && !(tx_cur.drain && expected_words.size() != 0)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= tx_cur.data;
        s_tlast  <= tx_cur.eos;
      end else begin
        s_tvalid <= 1'b0;
        if (tx_hold > 0) tx_hold--;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", m_tdata, 0);
        end else begin
          want = expected_words.pop_front();
          if (m_tdata !== want.data) report("out_byte", m_tdata, want.data);
          if (m_tlast !== want.last) report("out_last", m_tlast, want.last);
        end
        if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
        rx_hold = rx_fast ? 0 : $urandom_range(0, 7);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // directed: digit, lower-case A-B, C-F and non-hex c1 entities, then byte extremes
    push_text("&#x4a;", 1'b0);
    push_text("&#xb9;", 1'b0);
    push_text("&#xE0;", 1'b0);
    push_text("&#xz1;", 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1);
    while (pending_bytes.size() < RandomItems) begin
      if ($urandom_range(0, 9) < 7) begin
        push_ref_seq();
      end else begin
        repeat ($urandom_range(1, 3))
          push_byte(($urandom_range(0, 3) == 0) ? CH_AMP : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 15) == 0, 1'b0);
      end
      if ($urandom_range(0, 39) == 0) pending_bytes[$].drain = 1'b1;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || tx_have || expected_words.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
